### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
// Checked only while out of reset.
`define ASSERT_CLKRST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLKRST(label, prop, msg)
`endif
`endif

### hw/rtl/lsc_pkg.sv
// Shared constants, codes and types of the LRU cache tag model.
package lsc_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int STAMP_BITS   = 32;
    localparam int ADDR_BITS    = 64;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int SET_W        = MAX_SET_BITS;
    localparam int WAY_W        = 3;
    localparam int CNT_W        = 32;

    localparam int SETB_W    = 3;
    localparam int BLKB_W    = 4;
    localparam int WAYS_W    = 4;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int FUNC_W    = 2;

    // small queues between and behind the stages
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // access kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD_STORE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY     = 2'd1;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    typedef enum logic [1:0] {
        OUTCOME_HIT   = 2'd0,
        OUTCOME_FILL  = 2'd1,
        OUTCOME_EVICT = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [SETB_W-1:0] set_bits;
        logic [BLKB_W-1:0] block_bits;
        logic [WAYS_W-1:0] ways;
    } cfg_t;

    typedef struct packed {
        logic                  modify;
        logic [SET_W-1:0]      set_idx;
        logic [ADDR_BITS-1:0]  tag;
        logic [STAMP_BITS-1:0] stamp;
        logic                  stamp_sat;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  tag;
        logic [STAMP_BITS-1:0] stamp;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    typedef struct packed {
        outcome_t         outcome;
        logic [WAY_W-1:0] way_used;
        logic             last;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
        logic             stamp_sat;
    } result_t;

endpackage

### hw/rtl/lsc_front.sv
// Front end: config registers, input word filtering, set/tag split, use stamp.
module lsc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [lsc_pkg::FUNC_W-1:0]       func,
    input  logic [lsc_pkg::ADDR_BITS-1:0]    address,
    input  logic                             cfg_write,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsc_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             clearing,
    input  logic                             q_full,
    output logic                             q_push,
    output lsc_pkg::cmd_t                    q_data,
    output lsc_pkg::cfg_t                    cfg
);

    lsc_pkg::cfg_t                      cfg_reg;
    lsc_pkg::cfg_t                      cfg_next;
    logic [lsc_pkg::STAMP_BITS-1:0]     stamp_reg;
    logic [lsc_pkg::STAMP_BITS-1:0]     stamp_next;
    logic [lsc_pkg::ADDR_BITS-1:0]      shifted;
    logic [lsc_pkg::SET_W-1:0]          set_mask;
    logic                               is_data;

    assign full    = q_full | clearing;
    assign is_data = (func == lsc_pkg::FUNC_LOAD_STORE) || (func == lsc_pkg::FUNC_MODIFY);
    assign q_push  = push & ~full & is_data;

    // saturating use stamp, bumped once per data word
    assign stamp_next = (stamp_reg == '1) ? stamp_reg
                                          : stamp_reg + lsc_pkg::STAMP_BITS'(1);

    assign shifted  = address >> cfg_reg.block_bits;
    assign set_mask = ~({lsc_pkg::SET_W{1'b1}} << cfg_reg.set_bits);

    always_comb
    begin
        q_data.modify    = (func == lsc_pkg::FUNC_MODIFY);
        q_data.set_idx   = shifted[lsc_pkg::SET_W-1:0] & set_mask;
        q_data.tag       = shifted >> cfg_reg.set_bits;
        q_data.stamp     = stamp_next;
        q_data.stamp_sat = (stamp_next == '1);
    end

    // out-of-range values are clamped on write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                lsc_pkg::CFG_SET_BITS:
                begin
                    if (cfg_data[lsc_pkg::SETB_W-1:0] > lsc_pkg::SETB_W'(lsc_pkg::MAX_SET_BITS))
                        cfg_next.set_bits = lsc_pkg::SETB_W'(lsc_pkg::MAX_SET_BITS);
                    else
                        cfg_next.set_bits = cfg_data[lsc_pkg::SETB_W-1:0];
                end
                lsc_pkg::CFG_BLOCK_BITS:
                    cfg_next.block_bits = cfg_data[lsc_pkg::BLKB_W-1:0];
                lsc_pkg::CFG_WAYS:
                begin
                    if (cfg_data[lsc_pkg::WAYS_W-1:0] == '0)
                        cfg_next.ways = lsc_pkg::WAYS_W'(1);
                    else if (cfg_data[lsc_pkg::WAYS_W-1:0] > lsc_pkg::WAYS_W'(lsc_pkg::MAX_WAYS))
                        cfg_next.ways = lsc_pkg::WAYS_W'(lsc_pkg::MAX_WAYS);
                    else
                        cfg_next.ways = cfg_data[lsc_pkg::WAYS_W-1:0];
                end
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits   <= '0;
            cfg_reg.block_bits <= '0;
            cfg_reg.ways       <= lsc_pkg::WAYS_W'(1);
            stamp_reg          <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (q_push)
                stamp_reg <= stamp_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/lsc_cmd_queue.sv
// Two-entry command queue between the front end and the lookup engine.
module lsc_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  lsc_pkg::cmd_t wr_data,
    output logic          q_full,
    input  logic          rd_en,
    output lsc_pkg::cmd_t rd_data,
    output logic          q_empty
);

    lsc_pkg::cmd_t                 entries_reg [lsc_pkg::Q_DEPTH];
    logic [lsc_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [lsc_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [lsc_pkg::Q_CNT_W-1:0]   count_reg;
    logic [lsc_pkg::Q_CNT_W-1:0]   count_next;
    logic                          do_wr;
    logic                          do_rd;

    assign q_full  = (count_reg == lsc_pkg::Q_CNT_W'(lsc_pkg::Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en & ~q_full;
    assign do_rd   = rd_en & ~q_empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + lsc_pkg::Q_CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - lsc_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + lsc_pkg::Q_PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + lsc_pkg::Q_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### hw/rtl/lsc_back.sv
// Lookup engine: set row memory, way compare and LRU pick, write back, result queue.
module lsc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  lsc_pkg::cmd_t    q_data,
    output logic             q_pop,
    input  lsc_pkg::cfg_t    cfg,
    output logic             clearing,
    input  logic             pop,
    output logic             empty,
    output lsc_pkg::result_t res
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_PICK   = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_SECOND = 5'b10000
    } back_state_t;

    function automatic logic [lsc_pkg::CNT_W-1:0] sat_inc(input logic [lsc_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + lsc_pkg::CNT_W'(1);
    endfunction

    back_state_t                     state_reg;
    back_state_t                     state_next;
    logic [lsc_pkg::SET_W-1:0]       clear_reg;
    logic [lsc_pkg::SET_W-1:0]       clear_next;

    lsc_pkg::row_t                   mem [lsc_pkg::NUM_SETS];
    lsc_pkg::row_t                   row_reg;
    lsc_pkg::row_t                   row_wr;
    logic                            mem_we;
    logic [lsc_pkg::SET_W-1:0]       mem_waddr;
    lsc_pkg::row_t                   mem_wdata;

    lsc_pkg::cmd_t                   cmd_reg;
    lsc_pkg::outcome_t               outcome_reg;
    lsc_pkg::outcome_t               outcome_pick;
    logic [lsc_pkg::WAY_W-1:0]       way_reg;
    logic [lsc_pkg::WAY_W-1:0]       way_pick;

    logic [lsc_pkg::CNT_W-1:0]       hits_reg;
    logic [lsc_pkg::CNT_W-1:0]       hits_next;
    logic [lsc_pkg::CNT_W-1:0]       misses_reg;
    logic [lsc_pkg::CNT_W-1:0]       misses_next;
    logic [lsc_pkg::CNT_W-1:0]       evicts_reg;
    logic [lsc_pkg::CNT_W-1:0]       evicts_next;

    logic [lsc_pkg::MAX_WAYS-1:0]    in_use;
    logic [lsc_pkg::MAX_WAYS-1:0]    empty_vec;
    logic [lsc_pkg::MAX_WAYS-1:0]    match_vec;
    logic [lsc_pkg::MAX_WAYS-1:0]    older_vec;
    logic                            hit_found;
    logic                            empty_found;
    logic [lsc_pkg::WAY_W-1:0]       hit_way;
    logic [lsc_pkg::WAY_W-1:0]       empty_way;
    logic [lsc_pkg::WAY_W-1:0]       old_way;

    lsc_pkg::result_t                rq_reg [lsc_pkg::Q_DEPTH];
    logic [lsc_pkg::Q_PTR_W-1:0]     rq_wr_reg;
    logic [lsc_pkg::Q_PTR_W-1:0]     rq_rd_reg;
    logic [lsc_pkg::Q_CNT_W-1:0]     rq_cnt_reg;
    logic [lsc_pkg::Q_CNT_W-1:0]     rq_cnt_next;
    logic                            rq_full;
    logic                            rq_push;
    logic                            rq_pop;
    lsc_pkg::result_t                res_in;

    assign clearing = (state_reg == ST_CLEAR);

    // way classification on the registered row
    always_comb
    begin
        for (int w = 0; w < lsc_pkg::MAX_WAYS; w++)
        begin
            in_use[w]    = (lsc_pkg::WAYS_W'(w) < cfg.ways);
            empty_vec[w] = in_use[w] && (row_reg[w].stamp == '0);
            match_vec[w] = in_use[w] && (row_reg[w].stamp != '0)
                           && (row_reg[w].tag == cmd_reg.tag);
        end
        // oldest: strictly older than lower ways, no newer than higher ways
        for (int i = 0; i < lsc_pkg::MAX_WAYS; i++)
        begin
            older_vec[i] = in_use[i];
            for (int j = 0; j < lsc_pkg::MAX_WAYS; j++)
            begin
                if (in_use[j] && (j < i) && !(row_reg[i].stamp < row_reg[j].stamp))
                    older_vec[i] = 1'b0;
                if (in_use[j] && (j > i) && !(row_reg[i].stamp <= row_reg[j].stamp))
                    older_vec[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        hit_found   = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        old_way     = '0;
        for (int w = lsc_pkg::MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match_vec[w])
            begin
                hit_found = 1'b1;
                hit_way   = lsc_pkg::WAY_W'(w);
            end
            if (older_vec[w])
                old_way = lsc_pkg::WAY_W'(w);
        end
        for (int w = 0; w < lsc_pkg::MAX_WAYS; w++)
        begin
            if (empty_vec[w])
            begin
                empty_found = 1'b1;
                empty_way   = lsc_pkg::WAY_W'(w);
            end
        end
        if (hit_found)
        begin
            outcome_pick = lsc_pkg::OUTCOME_HIT;
            way_pick     = hit_way;
        end
        else if (empty_found)
        begin
            outcome_pick = lsc_pkg::OUTCOME_FILL;
            way_pick     = empty_way;
        end
        else
        begin
            outcome_pick = lsc_pkg::OUTCOME_EVICT;
            way_pick     = old_way;
        end
    end

    always_comb
    begin
        row_wr                = row_reg;
        row_wr[way_reg].tag   = cmd_reg.tag;
        row_wr[way_reg].stamp = cmd_reg.stamp;
    end

    always_comb
    begin
        state_next  = state_reg;
        clear_next  = clear_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = cmd_reg.set_idx;
        mem_wdata   = row_wr;
        rq_push     = 1'b0;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        evicts_next = evicts_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = clear_reg;
                mem_wdata  = '0;
                clear_next = clear_reg + lsc_pkg::SET_W'(1);
                if (clear_reg == lsc_pkg::SET_W'(lsc_pkg::NUM_SETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
                state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (!rq_full)
                begin
                    rq_push = 1'b1;
                    mem_we  = 1'b1;
                    if (outcome_reg == lsc_pkg::OUTCOME_HIT)
                        hits_next = sat_inc(hits_reg);
                    else
                        misses_next = sat_inc(misses_reg);
                    if (outcome_reg == lsc_pkg::OUTCOME_EVICT)
                        evicts_next = sat_inc(evicts_reg);
                    state_next = cmd_reg.modify ? ST_SECOND : ST_IDLE;
                end
            end
            ST_SECOND:
            begin
                // same set, tag and stamp: always a hit on the way just used
                if (!rq_full)
                begin
                    rq_push    = 1'b1;
                    hits_next  = sat_inc(hits_reg);
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_CLEAR;
        endcase

        res_in.outcome   = (state_reg == ST_SECOND) ? lsc_pkg::OUTCOME_HIT : outcome_reg;
        res_in.way_used  = way_reg;
        res_in.last      = (state_reg == ST_SECOND) || !cmd_reg.modify;
        res_in.hits      = hits_next;
        res_in.misses    = misses_next;
        res_in.evictions = evicts_next;
        res_in.stamp_sat = cmd_reg.stamp_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clear_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clear_reg  <= clear_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            evicts_reg <= evicts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_data;
        if (state_reg == ST_PICK)
        begin
            outcome_reg <= outcome_pick;
            way_reg     <= way_pick;
        end
    end

    // row memory, one row per set
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (q_pop)
            row_reg <= mem[q_data.set_idx];
    end

    // result queue
    assign rq_full = (rq_cnt_reg == lsc_pkg::Q_CNT_W'(lsc_pkg::Q_DEPTH));
    assign empty   = (rq_cnt_reg == '0);
    assign rq_pop  = pop & ~empty;
    assign res     = rq_reg[rq_rd_reg];

    always_comb
    begin
        rq_cnt_next = rq_cnt_reg;
        if (rq_push && !rq_pop)
            rq_cnt_next = rq_cnt_reg + lsc_pkg::Q_CNT_W'(1);
        else if (rq_pop && !rq_push)
            rq_cnt_next = rq_cnt_reg - lsc_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= '0;
            rq_rd_reg  <= '0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            rq_cnt_reg <= rq_cnt_next;
            if (rq_push)
                rq_wr_reg <= rq_wr_reg + lsc_pkg::Q_PTR_W'(1);
            if (rq_pop)
                rq_rd_reg <= rq_rd_reg + lsc_pkg::Q_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq_push)
            rq_reg[rq_wr_reg] <= res_in;
    end

endmodule

### hw/rtl/lru_set_associative_cache_model.sv
// Top level of the LRU set-associative cache tag model.
// Each accepted word (func, address) is split into set and tag by the front end and
// queued; the lookup engine reads the set's row from a single row memory, compares
// all ways and picks hit / highest empty way / oldest way in parallel, then writes the
// row back. A load or store passes through read, pick and write back; a modify adds
// a second result (the guaranteed hit on the same way). The engine takes no new word
// until that read-modify-write loop on the row memory is done, and waits while the
// result queue is full. Instruction fetches and unused codes are taken at once and
// give no result. After reset the engine clears all 64 sets of the row memory, one
// set per cycle; full stays high during that pass, config writes are still taken.
// Results come out of a 2-word queue (empty/pop), each carrying the running hit, miss
// and eviction counts after that lookup; last marks the final result of its input word.
`include "assert_macros.svh"

module lru_set_associative_cache_model (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [lsc_pkg::FUNC_W-1:0]       func,
    input  logic [lsc_pkg::ADDR_BITS-1:0]    address,
    output logic                             empty,
    input  logic                             pop,
    output logic [1:0]                       outcome,
    output logic [lsc_pkg::WAY_W-1:0]        way_used,
    output logic                             last,
    output logic [lsc_pkg::CNT_W-1:0]        hits_total,
    output logic [lsc_pkg::CNT_W-1:0]        misses_total,
    output logic [lsc_pkg::CNT_W-1:0]        evictions_total,
    output logic                             stamp_exhausted,
    input  logic                             cfg_write,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsc_pkg::CFG_W-1:0]        cfg_data
);

    logic             clearing;
    logic             q_full;
    logic             q_push;
    lsc_pkg::cmd_t    q_wdata;
    logic             q_pop;
    lsc_pkg::cmd_t    q_rdata;
    logic             q_empty;
    lsc_pkg::cfg_t    cfg;
    lsc_pkg::result_t res;

    // front end: config, filtering, address split, stamp
    lsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .address   (address),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .cfg       (cfg)
    );

    // decouples front end from lookup engine
    lsc_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .q_empty (q_empty)
    );

    // lookup engine with row memory and result queue
    lsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .clearing (clearing),
        .pop      (pop),
        .empty    (empty),
        .res      (res)
    );

    assign outcome         = res.outcome;
    assign way_used        = res.way_used;
    assign last            = res.last;
    assign hits_total      = res.hits;
    assign misses_total    = res.misses;
    assign evictions_total = res.evictions;
    assign stamp_exhausted = res.stamp_sat;

    // no input word while the row memory is being cleared
    `ASSERT_CLK(a_clear_blocks_input, clearing |-> full, "input open during clearing pass")
    // nothing can come out before the clearing pass ends
    `ASSERT_CLK(a_clear_no_result, clearing |-> empty, "result present during clearing pass")
    // a modify's first result is followed by its second, always a hit
    `ASSERT_CLKRST(a_modify_second_hit, (!empty && pop && !last) |=> (empty || outcome == lsc_pkg::OUTCOME_HIT), "second modify result is not a hit")
    // hit count never goes backwards across results
    `ASSERT_CLKRST(a_hits_monotonic, (!empty && pop) |=> (empty || hits_total >= $past(hits_total)), "hit count decreased")
    // once the stamp saturates it stays saturated
    `ASSERT_CLKRST(a_stamp_sticky, (!empty && pop && stamp_exhausted) |=> (empty || stamp_exhausted), "stamp saturation flag dropped")

endmodule
